// File: design/fcw_pkg.sv
// ----------------------------------------------------------------------------
// fcw_pkg
// shared types, codes and constants of the cluster chain walker
// ----------------------------------------------------------------------------
package fcw_pkg;

    localparam int TABLE_BYTES_DEF = 8192;
    localparam int MAX_CHAIN_DEF   = 64;

    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 48;
    localparam int STATUS_W  = 2;
    localparam int CLUSTER_W = 16;
    localparam int LEN_W     = 7;
    localparam int TADDR_W   = 13;
    localparam int FADDR_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALK = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_END = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FAT_IS_SIXTEEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CLUSTERS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START_BYTE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_BYTES   = 2'd3;

    localparam logic [16:0]          CLUSTER_BYTES_RST = 17'd512;
    localparam logic [11:0]          FAT12_MASK        = 12'hfff;
    localparam logic [11:0]          FAT12_RESERVED    = 12'hff0;
    localparam logic [15:0]          FAT12_EXTEND      = 16'hf000;
    localparam logic [15:0]          END_OF_CHAIN      = 16'hfff8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ_LO,
        S_READ_HI,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic walk_go;
        logic out_of_range;
        logic out_free;
        logic last_cluster;
    } stat_t;

    typedef struct packed {
        logic in_ready;
        logic do_check;
        logic do_read_lo;
        logic do_read_hi;
        logic do_emit;
    } ctl_t;

endpackage

// File: design/fcw_ram.sv
// ----------------------------------------------------------------------------
// fcw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fcw_pkg::TABLE_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fcw_seq.sv
// ----------------------------------------------------------------------------
// fcw_seq
// sequencer stepping one cluster through check, two byte reads and emit; an out of range cluster skips the reads
// ----------------------------------------------------------------------------
module fcw_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  fcw_pkg::stat_t stat,
    output fcw_pkg::ctl_t  ctl
);

    fcw_pkg::state_t state_reg;
    fcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcw_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcw_pkg::S_IDLE:
            begin
                if (stat.walk_go)
                begin
                    state_next = fcw_pkg::S_CHECK;
                end
            end
            fcw_pkg::S_CHECK:
            begin
                state_next = stat.out_of_range ? fcw_pkg::S_EMIT : fcw_pkg::S_READ_LO;
            end
            fcw_pkg::S_READ_LO:
            begin
                state_next = fcw_pkg::S_READ_HI;
            end
            fcw_pkg::S_READ_HI:
            begin
                state_next = fcw_pkg::S_EMIT;
            end
            fcw_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_cluster ? fcw_pkg::S_IDLE : fcw_pkg::S_CHECK;
                end
            end
            default:
            begin
                state_next = fcw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        case (state_reg)
            fcw_pkg::S_IDLE:    ctl.in_ready   = 1'b1;
            fcw_pkg::S_CHECK:   ctl.do_check   = 1'b1;
            fcw_pkg::S_READ_LO: ctl.do_read_lo = 1'b1;
            fcw_pkg::S_READ_HI: ctl.do_read_hi = 1'b1;
            fcw_pkg::S_EMIT:    ctl.do_emit    = stat.out_free;
            default:            ctl = '0;
        endcase
    end

endmodule

// File: design/fat_cluster_chain_walker_top.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_walker_top
// fat12 / fat16 table copy in a byte ram and a chain walker over it
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser op, tdata load or walk fields
//  m_*       out  m_tvalid/m_tready  tdata cluster and offset, tlast, tuser status
//  cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
//  a load item is written from the idle state; a walk steps each cluster through
//  check, low byte read, high byte read and emit, set by the single ram read port
//  a cluster out of range takes only check and emit and ends the walk
//  a stalled output holds the walk in its emit step; reset clears the sequencer,
//  config, counters and m_tvalid; the table ram holds garbage until loaded
// ----------------------------------------------------------------------------
module fat_cluster_chain_walker_top #(
    parameter int TABLE_BYTES = fcw_pkg::TABLE_BYTES_DEF,
    parameter int MAX_CHAIN   = fcw_pkg::MAX_CHAIN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // table_address, table_byte, start_cluster, chain_length
    input  logic [fcw_pkg::S_DATA_W-1:0]        s_tdata,
    // op
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // cluster_number, device_offset
    output logic [fcw_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tlast,
    // walk_status
    output logic [fcw_pkg::STATUS_W-1:0]        m_tuser,
    input  logic                                cfg_we,
    input  logic [fcw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcw_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam logic [17:0] TB = 18'(TABLE_BYTES);
    localparam logic [fcw_pkg::LEN_W-1:0] MAXC = fcw_pkg::LEN_W'(MAX_CHAIN);

    logic        fat16_reg;
    logic [15:0] total_reg;
    logic [31:0] dstart_reg;
    logic [16:0] cbytes_reg;

    logic [15:0] cur_reg;
    logic [fcw_pkg::LEN_W-1:0] rem_reg;
    logic [31:0] prod_reg;
    logic [fcw_pkg::FADDR_W-1:0] addr_reg;
    logic        oor_reg;
    logic        lo_ok_reg;
    logic        hi_ok_reg;
    logic [7:0]  lo_reg;
    logic [15:0] next_reg;

    logic        m_valid_reg;
    logic [fcw_pkg::M_DATA_W-1:0] m_data_reg;
    logic        m_last_reg;
    logic [fcw_pkg::STATUS_W-1:0] m_status_reg;

    fcw_pkg::stat_t stat;
    fcw_pkg::ctl_t  ctl;

    logic [fcw_pkg::TADDR_W-1:0] in_addr;
    logic [7:0]  in_byte;
    logic [15:0] in_start;
    logic [fcw_pkg::LEN_W-1:0] in_len;
    logic        accept;
    logic        load_we;
    logic [fcw_pkg::FADDR_W-1:0] addr_c;
    logic [fcw_pkg::FADDR_W-1:0] addr_hi;
    logic [fcw_pkg::FADDR_W-1:0] raddr_full;
    logic [7:0]  rdata;
    logic [7:0]  hi_byte;
    logic [15:0] word;
    logic [15:0] entry;
    logic [11:0] e12;
    logic [31:0] offset;
    logic        last_c;
    logic [fcw_pkg::STATUS_W-1:0] status_c;

    assign in_addr  = s_tdata[12:0];
    assign in_byte  = s_tdata[20:13];
    assign in_start = s_tdata[36:21];
    assign in_len   = s_tdata[43:37];
    assign accept   = s_tvalid & ctl.in_ready;
    assign load_we  = accept & (s_tuser == fcw_pkg::OP_LOAD) & ({5'd0, in_addr} < TB);

    assign stat.walk_go      = accept & (s_tuser == fcw_pkg::OP_WALK) & (in_len != '0);
    assign stat.out_of_range = cur_reg >= total_reg;
    assign stat.out_free     = ~m_valid_reg | m_tready;
    assign stat.last_cluster = oor_reg | (rem_reg == fcw_pkg::LEN_W'(1));

    fcw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    assign addr_c     = fat16_reg ? {cur_reg, 1'b0}
                                  : fcw_pkg::FADDR_W'(cur_reg) + fcw_pkg::FADDR_W'(cur_reg[15:1]);
    assign addr_hi    = addr_reg + fcw_pkg::FADDR_W'(1);
    assign raddr_full = ctl.do_read_lo ? addr_hi : addr_c;

    fcw_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(in_addr)),
        .wdata (in_byte),
        .raddr (AW'(raddr_full)),
        .rdata (rdata)
    );

    // entry decode
    always_comb
    begin
        hi_byte = hi_ok_reg ? rdata : 8'd0;
        word    = {hi_byte, lo_reg};
        e12     = cur_reg[0] ? word[15:4] : (word[11:0] & fcw_pkg::FAT12_MASK);
        if (fat16_reg)
        begin
            entry = word;
        end
        else if (e12 >= fcw_pkg::FAT12_RESERVED)
        begin
            entry = {4'd0, e12} | fcw_pkg::FAT12_EXTEND;
        end
        else
        begin
            entry = {4'd0, e12};
        end
    end

    assign offset   = dstart_reg + prod_reg - 32'({cbytes_reg, 1'b0});
    assign last_c   = stat.last_cluster;
    assign status_c = oor_reg ? fcw_pkg::STATUS_RANGE
                    : (last_c && next_reg < fcw_pkg::END_OF_CHAIN) ? fcw_pkg::STATUS_NO_END
                    : fcw_pkg::STATUS_OK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat16_reg  <= 1'b0;
            total_reg  <= '0;
            dstart_reg <= '0;
            cbytes_reg <= fcw_pkg::CLUSTER_BYTES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcw_pkg::REG_FAT_IS_SIXTEEN:  fat16_reg  <= cfg_wdata[0];
                fcw_pkg::REG_TOTAL_CLUSTERS:  total_reg  <= cfg_wdata[15:0];
                fcw_pkg::REG_DATA_START_BYTE: dstart_reg <= cfg_wdata;
                fcw_pkg::REG_CLUSTER_BYTES:   cbytes_reg <= cfg_wdata[16:0];
                default:                      fat16_reg  <= fat16_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            rem_reg <= '0;
            oor_reg <= 1'b0;
        end
        else
        begin
            if (stat.walk_go)
            begin
                cur_reg <= in_start;
                rem_reg <= (in_len > MAXC) ? MAXC : in_len;
            end
            else if (ctl.do_emit)
            begin
                cur_reg <= next_reg;
                rem_reg <= rem_reg - fcw_pkg::LEN_W'(1);
            end
            if (ctl.do_check)
            begin
                oor_reg <= stat.out_of_range;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_check)
        begin
            prod_reg  <= 32'(cur_reg * cbytes_reg);
            addr_reg  <= addr_c;
            lo_ok_reg <= {1'b0, addr_c} < TB;
        end
        if (ctl.do_read_lo)
        begin
            lo_reg    <= lo_ok_reg ? rdata : 8'd0;
            hi_ok_reg <= {1'b0, addr_hi} < TB;
        end
        if (ctl.do_read_hi)
        begin
            next_reg <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctl.do_emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_emit)
        begin
            m_data_reg   <= {offset, cur_reg};
            m_last_reg   <= last_c;
            m_status_reg <= status_c;
        end
    end

    assign s_tready = ctl.in_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule

// File: design/fcw_checker.sv
// ----------------------------------------------------------------------------
// fcw_checker
// port level checks of the chain walker, bound to the top level
// ----------------------------------------------------------------------------
module fcw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [fcw_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fcw_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast,
    input logic [fcw_pkg::STATUS_W-1:0]  m_tuser
);

    // error status only on the final item of a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != fcw_pkg::STATUS_OK |-> m_tlast)
        else $error("error status on a non-final item");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined walk status");

    // a walk of nonzero length makes the input busy
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == fcw_pkg::OP_WALK && s_tdata[43:37] != '0
        |=> !s_tready)
        else $error("input ready during a walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped under stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed under stall");

endmodule

bind fat_cluster_chain_walker_top fcw_checker u_fcw_checker (.*);
